/* sv/quadrature_encoder_with_debounce_unit_assert.svh */
// ============================================================================
// Quadrature encoder unit assertion macros
// Concurrent assertion wrappers clocked on clock and disabled during reset.
// ============================================================================
`ifndef QUADRATURE_ENCODER_WITH_DEBOUNCE_UNIT_ASSERT_SVH
`define QUADRATURE_ENCODER_WITH_DEBOUNCE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define QEDU_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed: label");

`define QEDU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`else

`define QEDU_ASSERT_SAME(label, ante, cons)

`define QEDU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* sv/qedu_pkg.sv */
// ============================================================================
// Quadrature encoder unit package
// Codes, widths and reset values shared by the encoder unit.
// ============================================================================
`default_nettype none

package qedu_pkg;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 2;

   typedef enum logic [2:0] {
      ACT_ENCODER     = 3'd0,
      ACT_BUTTON      = 3'd1,
      ACT_TAKE_DIFF   = 3'd2,
      ACT_TAKE_BUTTON = 3'd3,
      ACT_RESET_COUNT = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_CW     = 2'd1,
      EV_CCW    = 2'd2,
      EV_BUTTON = 2'd3
   } event_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_STEPS_PER_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PULSE_GAP   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTON_DEBOUNCE = 2'd2;

   localparam logic [4:0]  STEPS_MIN         = 5'd1;
   localparam logic [4:0]  STEPS_MAX         = 5'd16;
   localparam logic [4:0]  STEPS_RESET       = 5'd4;
   localparam logic [15:0] GAP_RESET         = 16'd1000;
   localparam logic [19:0] US_PER_MS         = 20'd1000;
   localparam logic [19:0] DEBOUNCE_US_RESET = 20'd50000;

endpackage

`default_nettype wire

/* sv/quadrature_encoder_with_debounce_unit.sv */
// ============================================================================
// Quadrature encoder with debounce
// Decodes timestamped encoder and button events and answers count queries.
// ============================================================================
// Every word is held in the input register and then moves to the result
// register, which presents its result; the move waits while the result
// register holds a result not yet taken. A new word is taken in every cycle
// while the result side keeps up. The rate is set by the single pass through
// the update logic, which reads and writes the step, press and stamp state in
// the same cycle. The debounce window is held in microseconds, converted once
// when the register is written.
`default_nettype none

`include "quadrature_encoder_with_debounce_unit_assert.svh"

module quadrature_encoder_with_debounce_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // action[2:0], time_us[34:3], level_a[35], level_b[36], zero padding
   input  wire logic [qedu_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // event_res[1:0], position[33:2], delta[65:34], pressed[66],
   // latest_event[68:67], zero padding
   output logic [qedu_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_we,
   input  wire logic [qedu_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [qedu_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import qedu_pkg::*;

   logic        in_valid_ff;
   action_type  in_action_ff;
   logic [31:0] in_time_ff;
   logic        in_a_ff;
   logic        in_b_ff;

   logic [4:0]  steps_ff;
   logic [15:0] gap_ff;
   logic [19:0] debounce_us_ff;

   logic        prev_a_ff, prev_a_in;
   logic [4:0]  tally_ff, tally_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] delta_ff, delta_in;
   logic        press_ff, press_in;
   event_type   recent_ff, recent_in;
   logic [31:0] step_stamp_ff, step_stamp_in;
   logic [31:0] press_stamp_ff, press_stamp_in;

   logic        out_valid_ff;
   event_type   out_event_ff, out_event_in;
   logic [31:0] out_delta_in;
   logic        out_press_in;
   logic [31:0] out_total_ff;
   logic [31:0] out_delta_ff;
   logic        out_press_ff;
   event_type   out_recent_ff;

   logic        advance;
   logic [31:0] step_gap;
   logic [31:0] press_gap;
   logic [4:0]  tally_inc;
   logic        steps_ok;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign step_gap   = in_time_ff - step_stamp_ff;
   assign press_gap  = in_time_ff - press_stamp_ff;
   assign tally_inc  = tally_ff + 5'd1;
   assign steps_ok   = (csr_wdata[4:0] >= STEPS_MIN) && (csr_wdata[4:0] <= STEPS_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_action_ff <= action_type'(req_tdata[2:0]);
         in_time_ff   <= req_tdata[34:3];
         in_a_ff      <= req_tdata[35];
         in_b_ff      <= req_tdata[36];
      end
   end

   always_comb begin
      prev_a_in      = prev_a_ff;
      tally_in       = tally_ff;
      total_in       = total_ff;
      delta_in       = delta_ff;
      press_in       = press_ff;
      recent_in      = recent_ff;
      step_stamp_in  = step_stamp_ff;
      press_stamp_in = press_stamp_ff;
      out_event_in   = EV_NONE;
      out_delta_in   = delta_ff;
      out_press_in   = press_ff;
      unique case (in_action_ff)
         ACT_ENCODER: begin
            if (step_gap >= {16'd0, gap_ff}) begin
               prev_a_in = in_a_ff;
               if (prev_a_ff && !in_a_ff) begin
                  tally_in = tally_inc;
                  if (tally_inc >= steps_ff) begin
                     tally_in      = 5'd0;
                     step_stamp_in = in_time_ff;
                     if (in_b_ff) begin
                        total_in     = total_ff + 32'd1;
                        delta_in     = delta_ff + 32'd1;
                        out_event_in = EV_CW;
                     end else begin
                        total_in     = total_ff - 32'd1;
                        delta_in     = delta_ff - 32'd1;
                        out_event_in = EV_CCW;
                     end
                     recent_in = out_event_in;
                  end
               end
            end
            out_delta_in = delta_in;
         end
         ACT_BUTTON: begin
            if (press_gap >= {12'd0, debounce_us_ff}) begin
               press_stamp_in = in_time_ff;
               press_in       = 1'b1;
               recent_in      = EV_BUTTON;
               out_event_in   = EV_BUTTON;
            end
            out_press_in = press_in;
         end
         ACT_TAKE_DIFF: begin
            delta_in = 32'd0;
         end
         ACT_TAKE_BUTTON: begin
            press_in = 1'b0;
         end
         ACT_RESET_COUNT: begin
            total_in     = 32'd0;
            delta_in     = 32'd0;
            out_delta_in = 32'd0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff       <= STEPS_RESET;
         gap_ff         <= GAP_RESET;
         debounce_us_ff <= DEBOUNCE_US_RESET;
         prev_a_ff      <= 1'b1;
         tally_ff       <= 5'd0;
         total_ff       <= 32'd0;
         delta_ff       <= 32'd0;
         press_ff       <= 1'b0;
         recent_ff      <= EV_NONE;
         step_stamp_ff  <= 32'd0;
         press_stamp_ff <= 32'd0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance && in_valid_ff) begin
            prev_a_ff      <= prev_a_in;
            tally_ff       <= tally_in;
            total_ff       <= total_in;
            delta_ff       <= delta_in;
            press_ff       <= press_in;
            recent_ff      <= recent_in;
            step_stamp_ff  <= step_stamp_in;
            press_stamp_ff <= press_stamp_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_STEPS_PER_COUNT: begin
                  if (steps_ok) begin
                     steps_ff <= csr_wdata[4:0];
                     tally_ff <= 5'd0;
                  end
               end
               CSR_MIN_PULSE_GAP: begin
                  gap_ff <= csr_wdata;
               end
               CSR_BUTTON_DEBOUNCE: begin
                  debounce_us_ff <= 20'(20'(csr_wdata[9:0]) * US_PER_MS);
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_event_ff  <= out_event_in;
         out_total_ff  <= total_in;
         out_delta_ff  <= out_delta_in;
         out_press_ff  <= out_press_in;
         out_recent_ff <= recent_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, out_recent_ff, out_press_ff, out_delta_ff, out_total_ff,
                        out_event_ff};

   `QEDU_ASSERT_SAME(tally_below_divider, 1'b1, tally_ff < steps_ff)
   `QEDU_ASSERT_SAME(event_sets_latest, rsp_tvalid && out_event_ff != EV_NONE,
                     out_recent_ff == out_event_ff)
   `QEDU_ASSERT_NEXT(reset_count_clears, advance && in_valid_ff && in_action_ff == ACT_RESET_COUNT,
                     total_ff == 32'd0 && out_total_ff == 32'd0 && out_delta_ff == 32'd0)
   `QEDU_ASSERT_NEXT(step_moves_stamp, advance && in_valid_ff && out_event_in == EV_CW,
                     step_stamp_ff == $past(in_time_ff))

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ============================================================================
// Quadrature encoder with debounce testbench
// Streams encoder, button and query words through the unit with random gaps
// on both sides and checks every result word against a cycle-free predictor
// or a typed value. A short directed table comes first, then random phases
// under several register settings, the extremes among them.
// ============================================================================

module testbench;

   import qedu_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES = 5;
   localparam int WORDS_PER_PHASE = 80;

   localparam logic [2:0] ACT_SPARE_5 = 3'd5;
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      event_type          latest_event;
      logic               pressed;
      logic signed [31:0] delta;
      logic signed [31:0] position;
      event_type          event_res;
   } result_t;

   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_TYPED,
      ROW_REG
   } row_kind_e;

   // For register rows the index travels in act and the value in t.
   typedef struct packed {
      row_kind_e   kind;
      logic [2:0]  act;
      logic [31:0] t;
      logic        a;
      logic        b;
      result_t     want;
   } plan_row_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic [REQ_DATA_W-1:0]    req_tdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [RSP_DATA_W-1:0]    rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic                     csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;

   // Predictor state
   logic [4:0]  div_cfg;
   logic [15:0] gap_cfg;
   logic [9:0]  bounce_cfg;
   logic        a_last;
   logic [4:0]  tally;
   logic [31:0] pos;
   logic [31:0] diff;
   logic        btn;
   event_type   last_ev;
   logic [31:0] step_time;
   logic [31:0] press_time;
   logic        word_filtered;

   result_t     expected_words [$];
   plan_row_t   plan [];
   result_t     want;
   result_t     seen;
   int          sent_words = 0;
   int          checked_words = 0;
   int          mismatches = 0;
   int          hold_cycles = 0;
   int          cycles = 0;

   quadrature_encoder_with_debounce_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int pick_wait(input bit calm);
      return calm ? 0 : $urandom_range(0, 18);
   endfunction

   function automatic result_t predict_word(input logic [2:0] act, input logic [31:0] t,
                                            input logic a, input logic b);
      result_t     r;
      logic [31:0] span;
      r = '0;
      r.event_res = EV_NONE;
      word_filtered = 1'b0;
      if (act == ACT_ENCODER) begin
         span = t - step_time;
         if (span < 32'(gap_cfg)) begin
            word_filtered = 1'b1;
         end else begin
            if (a_last && !a) begin
               tally = tally + 5'd1;
               if (tally >= div_cfg) begin
                  tally = 5'd0;
                  step_time = t;
                  if (b) begin
                     pos = pos + 32'd1;
                     diff = diff + 32'd1;
                     r.event_res = EV_CW;
                  end else begin
                     pos = pos - 32'd1;
                     diff = diff - 32'd1;
                     r.event_res = EV_CCW;
                  end
                  last_ev = r.event_res;
               end
            end
            a_last = a;
         end
      end else if (act == ACT_BUTTON) begin
         span = t - press_time;
         if (span / 32'd1000 < 32'(bounce_cfg)) begin
            word_filtered = 1'b1;
         end else begin
            press_time = t;
            btn = 1'b1;
            last_ev = EV_BUTTON;
            r.event_res = EV_BUTTON;
         end
      end else if (act == ACT_RESET_COUNT) begin
         pos = '0;
         diff = '0;
      end
      r.position = pos;
      r.delta = diff;
      r.pressed = btn;
      if (act == ACT_TAKE_DIFF)
         diff = '0;
      else if (act == ACT_TAKE_BUTTON)
         btn = 1'b0;
      r.latest_event = last_ev;
      return r;
   endfunction

   function automatic plan_row_t row_word(input logic [2:0] act, input logic [31:0] t,
                                          input logic a, input logic b);
      return '{ROW_PREDICT, act, t, a, b, '0};
   endfunction

   function automatic plan_row_t row_typed(input logic [2:0] act, input logic [31:0] t,
                                           input logic a, input logic b, input event_type ev,
                                           input logic signed [31:0] p,
                                           input logic signed [31:0] d,
                                           input logic pr, input event_type latest);
      result_t r;
      r.event_res = ev;
      r.position = p;
      r.delta = d;
      r.pressed = pr;
      r.latest_event = latest;
      return '{ROW_TYPED, act, t, a, b, r};
   endfunction

   function automatic plan_row_t row_reg(input logic [CSR_INDEX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] val);
      return '{ROW_REG, {1'b0, idx}, {16'd0, val}, 1'b0, 1'b0, '0};
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] exp_val);
      if (mismatches < 50)
         $display("mismatch on result word %0d, %s: got 0x%0h, expected 0x%0h",
                  checked_words, field, got, exp_val);
      mismatches++;
   endtask

   task automatic send_word(input logic [2:0] act, input logic [31:0] t, input logic a,
                            input logic b, input logic typed, input result_t typed_want);
      int      gap;
      result_t guess;
      gap = pick_wait(((sent_words / 40) % 3) == 1);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata <= {3'b000, b, a, t, act};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      guess = predict_word(act, t, a, b);
      expected_words.push_back(typed ? typed_want : guess);
      sent_words++;
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_STEPS_PER_COUNT: begin
            if (val[4:0] >= STEPS_MIN && val[4:0] <= STEPS_MAX) begin
               div_cfg = val[4:0];
               tally = 5'd0;
            end
         end
         CSR_MIN_PULSE_GAP: gap_cfg = val;
         CSR_BUTTON_DEBOUNCE: bounce_cfg = val[9:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_cycles = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            checked_words++;
            if (expected_words.size() == 0) begin
               report_mismatch("word with nothing expected", rsp_tdata[31:0], 32'd0);
            end else begin
               want = expected_words.pop_front();
               seen = result_t'(rsp_tdata[68:0]);
               if (seen.event_res !== want.event_res)
                  report_mismatch("event_res", 32'(seen.event_res), 32'(want.event_res));
               if (seen.position !== want.position)
                  report_mismatch("position", seen.position, want.position);
               if (seen.delta !== want.delta)
                  report_mismatch("delta", seen.delta, want.delta);
               if (seen.pressed !== want.pressed)
                  report_mismatch("pressed", 32'(seen.pressed), 32'(want.pressed));
               if (seen.latest_event !== want.latest_event)
                  report_mismatch("latest_event", 32'(seen.latest_event),
                                  32'(want.latest_event));
            end
            hold_cycles = pick_wait(((checked_words / 50) % 3) == 2);
         end
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin
      logic [2:0]  act;
      logic [31:0] t;
      logic        a;
      logic        b;
      logic        spin_cw;
      logic        phase_a;
      logic [31:0] now_us;
      int          pick;
      int          counted;

      div_cfg = STEPS_RESET;
      gap_cfg = GAP_RESET;
      bounce_cfg = 10'(DEBOUNCE_US_RESET / US_PER_MS);
      a_last = 1'b1;
      tally = '0;
      pos = '0;
      diff = '0;
      btn = 1'b0;
      last_ev = EV_NONE;
      step_time = '0;
      press_time = '0;
      spin_cw = 1'b1;
      phase_a = 1'b1;
      now_us = $urandom();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      plan = '{
         row_typed(ACT_TAKE_DIFF, 32'd0, 1'b0, 1'b0, EV_NONE, 0, 0, 1'b0, EV_NONE),
         row_typed(ACT_ENCODER, 32'd0, 1'b0, 1'b1, EV_NONE, 0, 0, 1'b0, EV_NONE),
         row_typed(ACT_BUTTON, 32'd49999, 1'b0, 1'b0, EV_NONE, 0, 0, 1'b0, EV_NONE),
         row_typed(ACT_BUTTON, 32'd50000, 1'b0, 1'b0, EV_BUTTON, 0, 0, 1'b1, EV_BUTTON),
         row_typed(ACT_TAKE_BUTTON, 32'hFFFF_FFFF, 1'b1, 1'b1, EV_NONE, 0, 0, 1'b1,
                   EV_BUTTON),
         row_word(ACT_TAKE_BUTTON, 32'd0, 1'b0, 1'b0),
         row_word(ACT_ENCODER, 32'd1000, 1'b0, 1'b1),
         row_word(ACT_ENCODER, 32'd1001, 1'b1, 1'b1),
         row_word(ACT_ENCODER, 32'd1002, 1'b0, 1'b1),
         row_word(ACT_ENCODER, 32'd1003, 1'b1, 1'b1),
         row_word(ACT_ENCODER, 32'd1004, 1'b0, 1'b1),
         row_word(ACT_ENCODER, 32'd1005, 1'b1, 1'b1),
         row_word(ACT_ENCODER, 32'd1006, 1'b0, 1'b1),
         row_word(ACT_ENCODER, 32'd1500, 1'b1, 1'b0),
         row_word(ACT_ENCODER, 32'hFFFF_FFFF, 1'b1, 1'b0),
         row_word(ACT_TAKE_DIFF, 32'd0, 1'b0, 1'b0),
         row_word(ACT_RESET_COUNT, 32'd0, 1'b0, 1'b0),
         row_word(ACT_SPARE_5, 32'h5A5A_A5A5, 1'b1, 1'b1),
         row_word(ACT_SPARE_6, 32'hA5A5_5A5A, 1'b0, 1'b1),
         row_word(ACT_SPARE_7, 32'hFFFF_FFFF, 1'b1, 1'b0),
         row_reg(CSR_STEPS_PER_COUNT, 16'd2),
         row_reg(CSR_MIN_PULSE_GAP, 16'd0),
         row_reg(CSR_BUTTON_DEBOUNCE, 16'd0),
         row_word(ACT_ENCODER, 32'd10, 1'b0, 1'b0),
         row_reg(CSR_STEPS_PER_COUNT, 16'd0),
         row_reg(CSR_STEPS_PER_COUNT, 16'hFFF1),
         row_word(ACT_ENCODER, 32'd11, 1'b1, 1'b0),
         row_word(ACT_ENCODER, 32'd12, 1'b0, 1'b0),
         row_reg(CSR_STEPS_PER_COUNT, 16'd1),
         row_word(ACT_ENCODER, 32'd12, 1'b1, 1'b0),
         row_word(ACT_ENCODER, 32'd12, 1'b0, 1'b0),
         row_word(ACT_BUTTON, 32'd0, 1'b0, 1'b0),
         row_word(ACT_TAKE_BUTTON, 32'd0, 1'b0, 1'b0),
         row_reg(CSR_SPARE, 16'hFFFF)
      };

      foreach (plan[i]) begin
         case (plan[i].kind)
            ROW_REG: write_reg(plan[i].act[1:0], plan[i].t[15:0]);
            ROW_TYPED: send_word(plan[i].act, plan[i].t, plan[i].a, plan[i].b, 1'b1,
                                 plan[i].want);
            default: send_word(plan[i].act, plan[i].t, plan[i].a, plan[i].b, 1'b0, '0);
         endcase
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_STEPS_PER_COUNT, 16'(STEPS_MIN));
               write_reg(CSR_MIN_PULSE_GAP, 16'd0);
               write_reg(CSR_BUTTON_DEBOUNCE, 16'd0);
            end
            1: begin
               write_reg(CSR_STEPS_PER_COUNT, 16'(STEPS_MAX));
               write_reg(CSR_MIN_PULSE_GAP, 16'hFFFF);
               write_reg(CSR_BUTTON_DEBOUNCE, 16'd1000);
            end
            default: begin
               write_reg(CSR_STEPS_PER_COUNT, {11'($urandom()), 5'($urandom_range(1, 16))});
               write_reg(CSR_MIN_PULSE_GAP, ($urandom_range(0, 1) == 1) ?
                         16'($urandom_range(0, 3000)) : 16'($urandom()));
               write_reg(CSR_BUTTON_DEBOUNCE,
                         {6'($urandom()), 10'($urandom_range(0, 1000))});
               write_reg(CSR_STEPS_PER_COUNT, {11'($urandom()), ($urandom_range(0, 1) == 1) ?
                         5'd0 : 5'($urandom_range(17, 31))});
               write_reg(CSR_SPARE, 16'($urandom()));
            end
         endcase

         counted = 0;
         while (counted < WORDS_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            t = $urandom();
            a = 1'($urandom_range(0, 1));
            b = 1'($urandom_range(0, 1));
            if (pick < 60) begin
               act = ACT_ENCODER;
               if ($urandom_range(0, 19) == 0)
                  spin_cw = ~spin_cw;
               if ($urandom_range(0, 9) != 0)
                  phase_a = ~phase_a;
               a = phase_a;
               b = spin_cw;
               case ($urandom_range(0, 9))
                  0: t = step_time + 32'(gap_cfg) - 32'd1;
                  1: t = step_time + 32'(gap_cfg);
                  2: ;
                  default: begin
                     now_us = now_us + 32'($urandom_range(0, 600));
                     if ($urandom_range(0, 3) == 0)
                        now_us = now_us + 32'(gap_cfg);
                     t = now_us;
                  end
               endcase
            end else if (pick < 72) begin
               act = ACT_BUTTON;
               case ($urandom_range(0, 5))
                  0: t = press_time + 32'(bounce_cfg) * 32'd1000 - 32'd1;
                  1: t = press_time + 32'(bounce_cfg) * 32'd1000;
                  2: ;
                  default: begin
                     now_us = now_us + 32'($urandom_range(0, 70000));
                     t = now_us;
                  end
               endcase
            end else if (pick < 80) begin
               act = ACT_TAKE_DIFF;
            end else if (pick < 88) begin
               act = ACT_TAKE_BUTTON;
            end else if (pick < 92) begin
               act = ACT_RESET_COUNT;
            end else if (pick < 96) begin
               act = 3'($urandom_range(5, 7));
            end else begin
               act = 3'($urandom_range(0, 7));
            end
            send_word(act, t, a, b, 1'b0, '0);
            if (!word_filtered)
               counted++;
         end
      end

      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/qedu_pkg.sv
sv/quadrature_encoder_with_debounce_unit.sv
bench/testbench.sv
